// ----- rtl/sbox_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_pkg
// Shared widths, types and register codes for the segment/box overlap test.
// ----------------------------------------------------------------------------
package sbox_pkg;

  localparam int NumAxes = 3;
  localparam int CoordW  = 16;  // Q8.8 coordinate
  localparam int ExtW    = 17;  // max - min
  localparam int DirW    = 17;  // end - start
  localparam int OffW    = 18;  // start + end - min - max
  localparam int MagW    = 17;  // |end - start|
  localparam int FaceW   = 20;  // face axis compare
  localparam int ProdW   = 35;  // 17 x 18 signed product
  localparam int CrossW  = 36;  // sum or difference of two products
  localparam int CfgIdxW = 3;

  // Other two axes for each cross axis
  localparam int AxisB [NumAxes] = '{1, 2, 0};
  localparam int AxisC [NumAxes] = '{2, 0, 1};

  typedef enum logic [CfgIdxW-1:0] {
    RegMinX = 3'd0,
    RegMinY = 3'd1,
    RegMinZ = 3'd2,
    RegMaxX = 3'd3,
    RegMaxY = 3'd4,
    RegMaxZ = 3'd5
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ExtW-1:0]   ext_t;
  typedef logic signed [DirW-1:0]   dir_t;
  typedef logic signed [OffW-1:0]   off_t;
  typedef logic        [MagW-1:0]   mag_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [CrossW-1:0] cross_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] lo;
    coord_t [NumAxes-1:0] hi;
  } box_t;

  typedef struct packed {
    coord_t [NumAxes-1:0] s;
    coord_t [NumAxes-1:0] e;
  } seg_t;

  typedef struct packed {
    ext_t [NumAxes-1:0] ext;
    dir_t [NumAxes-1:0] dir;
    off_t [NumAxes-1:0] off;
    mag_t [NumAxes-1:0] mag;
  } prep_t;

  typedef struct packed {
    logic                face_sep;
    prod_t [NumAxes-1:0] pos;
    prod_t [NumAxes-1:0] neg;
    prod_t [NumAxes-1:0] ea_b;
    prod_t [NumAxes-1:0] ea_c;
  } prod_s_t;

  typedef struct packed {
    logic                 face_sep;
    cross_t [NumAxes-1:0] cr;
    cross_t [NumAxes-1:0] rhs;
  } cross_s_t;

endpackage

// ----- rtl/sbox_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_if
// Valid/ready channels of the overlap test: segment in, hit out, register
// writes.
// ----------------------------------------------------------------------------
interface sbox_seg_if import sbox_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

interface sbox_hit_if ();
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

interface sbox_cfg_if import sbox_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  coord_t             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/sbox_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_cfg_regs
// Box corner registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module sbox_cfg_regs import sbox_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbox_cfg_if.sink   cfg_i,
  output box_t       box_o
);

  box_t box_q;

  assign cfg_i.ready = 1'b1;
  assign box_o       = box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_reg_e'(cfg_i.index))
        RegMinX: box_q.lo[0] <= cfg_i.data;
        RegMinY: box_q.lo[1] <= cfg_i.data;
        RegMinZ: box_q.lo[2] <= cfg_i.data;
        RegMaxX: box_q.hi[0] <= cfg_i.data;
        RegMaxY: box_q.hi[1] <= cfg_i.data;
        RegMaxZ: box_q.hi[2] <= cfg_i.data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  a_min_x_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready && (cfg_i.index == RegMinX)
    |=> box_q.lo[0] == $past(cfg_i.data))
    else $error("box_min_x did not take the written value");

  a_unmapped_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready && (cfg_i.index > RegMaxZ)
    |=> $stable(box_q))
    else $error("unmapped register write changed the box");

endmodule

// ----- rtl/sbox_prep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_prep
// First stage: doubled extent, direction, center offset and |direction|.
// ----------------------------------------------------------------------------
module sbox_prep import sbox_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  seg_t  seg_i,
  input  box_t  box_i,
  output logic  valid_o,
  input  logic  ready_i,
  output prep_t data_o
);

  ext_t ext_w [NumAxes];
  dir_t dir_w [NumAxes];
  off_t off_w [NumAxes];
  mag_t mag_w [NumAxes];

  prep_t data_d, data_q;
  logic  valid_q;

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    assign ext_w[a] = ExtW'($signed(box_i.hi[a])) - ExtW'($signed(box_i.lo[a]));
    assign dir_w[a] = DirW'($signed(seg_i.e[a])) - DirW'($signed(seg_i.s[a]));
    assign off_w[a] = OffW'($signed(seg_i.s[a])) + OffW'($signed(seg_i.e[a]))
                    - OffW'($signed(box_i.lo[a])) - OffW'($signed(box_i.hi[a]));
    // |dir| never exceeds 65535, so it fits unsigned in the same width
    assign mag_w[a] = dir_w[a][DirW-1] ? MagW'(-dir_w[a]) : MagW'(dir_w[a]);
  end

  always_comb begin
    data_d.ext = {ext_w[2], ext_w[1], ext_w[0]};
    data_d.dir = {dir_w[2], dir_w[1], dir_w[0]};
    data_d.off = {off_w[2], off_w[1], off_w[0]};
    data_d.mag = {mag_w[2], mag_w[1], mag_w[0]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/sbox_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_mul
// Second stage: face axis tests and the twelve cross-axis products.
// ----------------------------------------------------------------------------
module sbox_mul import sbox_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    ready_o,
  input  prep_t   data_i,
  output logic    valid_o,
  input  logic    ready_i,
  output prod_s_t data_o
);

  logic signed [FaceW-1:0] face_lhs [NumAxes];
  logic signed [FaceW-1:0] face_rhs [NumAxes];
  logic        [OffW-1:0]  off_mag  [NumAxes];
  logic                    face_sep [NumAxes];

  prod_t pos_w  [NumAxes];
  prod_t neg_w  [NumAxes];
  prod_t ea_b_w [NumAxes];
  prod_t ea_c_w [NumAxes];

  prod_s_t data_d, data_q;
  logic    valid_q;

  for (genvar a = 0; a < NumAxes; a++) begin : g_axis
    localparam int B = AxisB[a];
    localparam int C = AxisC[a];

    // Face axis: |off| > ext + |dir| separates
    assign off_mag[a]  = data_i.off[a][OffW-1] ? OffW'(-data_i.off[a])
                                               : OffW'(data_i.off[a]);
    assign face_lhs[a] = FaceW'(off_mag[a]);
    assign face_rhs[a] = FaceW'($signed(data_i.ext[a])) + FaceW'(data_i.mag[a]);
    assign face_sep[a] = face_lhs[a] > face_rhs[a];

    // Cross axis a: dir[b]*off[c] - dir[c]*off[b] against
    // ext[b]*|dir[c]| + ext[c]*|dir[b]|
    assign pos_w[a]  = $signed(data_i.dir[B]) * $signed(data_i.off[C]);
    assign neg_w[a]  = $signed(data_i.dir[C]) * $signed(data_i.off[B]);
    assign ea_b_w[a] = $signed(data_i.ext[B]) * $signed({1'b0, data_i.mag[C]});
    assign ea_c_w[a] = $signed(data_i.ext[C]) * $signed({1'b0, data_i.mag[B]});
  end

  always_comb begin
    data_d.face_sep = face_sep[0] || face_sep[1] || face_sep[2];
    data_d.pos      = {pos_w[2], pos_w[1], pos_w[0]};
    data_d.neg      = {neg_w[2], neg_w[1], neg_w[0]};
    data_d.ea_b     = {ea_b_w[2], ea_b_w[1], ea_b_w[0]};
    data_d.ea_c     = {ea_c_w[2], ea_c_w[1], ea_c_w[0]};
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/sbox_cmp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbox_cmp
// Third and fourth stages: form the cross terms, compare, register the hit.
// ----------------------------------------------------------------------------
module sbox_cmp import sbox_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  prod_s_t    data_i,
  sbox_hit_if.source hit_o
);

  cross_t cr_w  [NumAxes];
  cross_t rhs_w [NumAxes];
  cross_t cr_mag [NumAxes];
  logic   cross_sep [NumAxes];

  cross_s_t s3_d, s3_q;
  logic     s3_valid_q;
  logic     s3_ready;

  logic hit_d, hit_q;
  logic out_valid_q;
  logic out_ready;

  // Stage 3: difference and sum of the registered products
  for (genvar a = 0; a < NumAxes; a++) begin : g_s3
    assign cr_w[a]  = CrossW'($signed(data_i.pos[a])) - CrossW'($signed(data_i.neg[a]));
    assign rhs_w[a] = CrossW'($signed(data_i.ea_b[a])) + CrossW'($signed(data_i.ea_c[a]));
  end

  always_comb begin
    s3_d.face_sep = data_i.face_sep;
    s3_d.cr       = {cr_w[2], cr_w[1], cr_w[0]};
    s3_d.rhs      = {rhs_w[2], rhs_w[1], rhs_w[0]};
  end

  assign out_ready = !out_valid_q || hit_o.ready;
  assign s3_ready  = !s3_valid_q || out_ready;
  assign ready_o   = s3_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && valid_i) begin
      s3_q <= s3_d;
    end
  end

  // Stage 4: |cross| > rhs separates; magnitude stays below 2^34
  for (genvar a = 0; a < NumAxes; a++) begin : g_s4
    assign cr_mag[a]    = s3_q.cr[a][CrossW-1] ? -s3_q.cr[a] : s3_q.cr[a];
    assign cross_sep[a] = cr_mag[a] > $signed(s3_q.rhs[a]);
  end

  assign hit_d = !(s3_q.face_sep || cross_sep[0] || cross_sep[1] || cross_sep[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s3_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o.valid = out_valid_q;
  assign hit_o.hit   = hit_q;

  a_face_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && s3_q.face_sep && out_ready |=> !hit_q)
    else $error("face separation did not produce a miss");

  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q && !out_valid_q |=> out_valid_q)
    else $error("empty output register did not take the waiting item");

endmodule

// ----- rtl/segment_box_overlap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_box_overlap_test
// Segment versus axis-aligned box overlap by the separating axis test.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_i  : register writes, index 0..5 = box min x/y/z, max x/y/z (Q8.8).
//            Always ready; unmapped indexes are dropped. Write only while
//            no item is in flight.
//   seg_i  : one item per segment (start and end points, Q8.8).
//   hit_o  : one item per segment, hit = 1 when the segment touches the box
//            (surface contact counts), 0 when a separating axis exists.
// Pipeline: four register stages (prep, products, cross terms, hit). An item
//   taken on seg_i passes through them in that order on its way to hit_o.
// Throughput: one item per cycle while hit_o is taken; the twelve 17x18
//   products in stage two set the depth of the pipe, not its rate.
// Reset: clears every stage valid bit and the box registers to zero.
// Stall: when hit_o is not taken, the pipe keeps filling its empty stages
//   and then holds; seg_i.ready drops only when stage one is full and
//   cannot advance. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module segment_box_overlap_test import sbox_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbox_seg_if.sink   seg_i,
  sbox_cfg_if.sink   cfg_i,
  sbox_hit_if.source hit_o
);

  box_t    box;
  seg_t    seg;

  logic    s1_valid, s1_ready;
  prep_t   s1_data;
  logic    s2_valid, s2_ready;
  prod_s_t s2_data;

  // Gather the input item into a vector form per axis
  always_comb begin
    seg.s = {seg_i.start_z, seg_i.start_y, seg_i.start_x};
    seg.e = {seg_i.end_z, seg_i.end_y, seg_i.end_x};
  end

  sbox_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .box_o  (box)
  );

  // Stage 1: extent, direction, offset, |direction|
  sbox_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_i.valid),
    .ready_o (seg_i.ready),
    .seg_i   (seg),
    .box_i   (box),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Stage 2: face tests and cross-axis products
  sbox_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // Stages 3 and 4: cross terms, compares, result register
  sbox_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .hit_o   (hit_o)
  );

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_i.valid && seg_i.ready |=> s1_valid)
    else $error("accepted item did not reach stage one");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> seg_i.ready)
    else $error("input stalled with stage one empty");

endmodule

// ----- test/tb_segment_box_overlap_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_box_overlap_test
// Self-checking bench for the segment/box separating axis overlap test.
// ----------------------------------------------------------------------------
// Load box corners over the register port, stream segments into the block and
// compare each hit flag with a local predictor that repeats the face and cross
// axis tests on doubled extents. Start with a directed table, then run random
// phases, each with a new box. In most random phases the sender paces items in
// bursts; the receiver stalls on a pattern of its own and once holds off long
// enough to back the pipe up into the segment input.
// ----------------------------------------------------------------------------
module tb_segment_box_overlap_test;
  import sbox_pkg::*;

  localparam int NumPhases  = 9;
  localparam int PhaseItems = 45;
  localparam int StallLimit = 2000;  // cycles with no handshake at all
  localparam int DrainWait  = 8;     // longer than the pipe is deep
  localparam int LongHold   = 120;

  // Indexes that map to no register; writes to them must change nothing
  localparam logic [CfgIdxW-1:0] IdxSpare0 = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxSpare1 = 3'd7;

  typedef struct {
    int   box_sel;
    seg_t seg;
    bit   typed;  // hit is given in the row instead of predicted
    logic hit;
  } seg_row_t;

  logic clk;
  logic rst_n;

  sbox_seg_if seg_bus ();
  sbox_cfg_if cfg_bus ();
  sbox_hit_if hit_bus ();

  segment_box_overlap_test u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .seg_i  (seg_bus),
    .cfg_i  (cfg_bus),
    .hit_o  (hit_bus)
  );

  // Box as the block should hold it; follows every accepted register write
  coord_t box_lo [3] = '{16'sd0, 16'sd0, 16'sd0};
  coord_t box_hi [3] = '{16'sd0, 16'sd0, 16'sd0};

  logic     hit_expect_q [$];
  int       items_sent   = 0;
  int       results_seen = 0;
  int       err_count    = 0;
  int       idle_cycles  = 0;
  bit       bursty       = 0;
  int       burst_left   = 0;
  seg_row_t seg_rows [$];

  // Ride along with the segment payload so the monitor knows which rows carry
  // a hand-typed answer
  bit   row_typed;
  logic row_hit;

  // Corner sets of the directed part: reset zero, unit cube, full range, and
  // a cube turned inside out on x
  coord_t dir_box_lo [4][3] = '{'{16'sd0, 16'sd0, 16'sd0},
                                '{-16'sd256, -16'sd256, -16'sd256},
                                '{-16'sd32768, -16'sd32768, -16'sd32768},
                                '{16'sd256, -16'sd256, -16'sd256}};
  coord_t dir_box_hi [4][3] = '{'{16'sd0, 16'sd0, 16'sd0},
                                '{16'sd256, 16'sd256, 16'sd256},
                                '{16'sd32767, 16'sd32767, 16'sd32767},
                                '{-16'sd256, 16'sd256, 16'sd256}};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: separating axis test with every center, extent and direction
  // kept doubled, so all compares stay exact
  // --------------------------------------------------------------------------
  function automatic longint mag64(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic predict_hit(input coord_t p0 [3], input coord_t p1 [3]);
    longint span [3];
    longint run  [3];
    longint ctr  [3];
    longint lhs, rhs;
    logic   touch;
    int     b, c;
    touch = 1'b1;
    for (int a = 0; a < 3; a++) begin
      span[a] = longint'(box_hi[a]) - longint'(box_lo[a]);
      run[a]  = longint'(p1[a]) - longint'(p0[a]);
      ctr[a]  = longint'(p0[a]) + longint'(p1[a]) - longint'(box_lo[a])
                - longint'(box_hi[a]);
    end
    // Box face normals
    for (int a = 0; a < 3; a++) begin
      if (mag64(ctr[a]) > span[a] + mag64(run[a])) touch = 1'b0;
    end
    // Segment direction crossed with each box axis
    for (int a = 0; a < 3; a++) begin
      b   = (a + 1) % 3;
      c   = (a + 2) % 3;
      lhs = run[b] * ctr[c] - run[c] * ctr[b];
      rhs = span[b] * mag64(run[c]) + span[c] * mag64(run[b]);
      if (mag64(lhs) > rhs) touch = 1'b0;
    end
    return touch;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic coord_t clamp16(input int v);
    if (v < -32768) return coord_t'(-32768);
    if (v > 32767)  return coord_t'(32767);
    return coord_t'(v);
  endfunction

  function automatic int rand16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Pick a coordinate in the span of lo..hi widened by margin on both sides
  function automatic coord_t pick_near(input int lo, input int hi, input int margin);
    int l, h;
    l = (lo < hi) ? lo : hi;
    h = (lo < hi) ? hi : lo;
    l = int'(clamp16(l - margin));
    h = int'(clamp16(h + margin));
    return coord_t'(l + int'($urandom_range(0, h - l)));
  endfunction

  function automatic void add_row(input int box_sel, input int sx, input int sy,
                                  input int sz, input int ex, input int ey,
                                  input int ez, input bit typed, input logic hit);
    seg_row_t r;
    r.box_sel  = box_sel;
    r.seg.s[0] = coord_t'(sx);
    r.seg.s[1] = coord_t'(sy);
    r.seg.s[2] = coord_t'(sz);
    r.seg.e[0] = coord_t'(ex);
    r.seg.e[1] = coord_t'(ey);
    r.seg.e[2] = coord_t'(ez);
    r.typed    = typed;
    r.hit      = hit;
    seg_rows.insert(seg_rows.size(), r);
  endfunction

  // Write all six corner registers back to back, optionally followed by a
  // write to an unmapped index. Call only with nothing in flight.
  task automatic load_box(input coord_t lo [3], input coord_t hi [3], input bit add_spare);
    logic [CfgIdxW-1:0] idx_q [$];
    coord_t             val_q [$];
    idx_q = '{RegMinX, RegMinY, RegMinZ, RegMaxX, RegMaxY, RegMaxZ};
    val_q = '{lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]};
    if (add_spare) begin
      idx_q.insert(idx_q.size(), $urandom_range(0, 1) ? IdxSpare0 : IdxSpare1);
      val_q.insert(val_q.size(), coord_t'($urandom));
    end
    foreach (idx_q[i]) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx_q[i];
      cfg_bus.data  <= val_q[i];
      do @(posedge clk); while (!(cfg_bus.valid && cfg_bus.ready));
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Offer one segment; keep valid high across items inside a burst and drop
  // it only for a gap
  task automatic send_segment(input seg_t sg, input bit typed, input logic hit);
    if (bursty && burst_left == 0) begin
      seg_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left > 0) burst_left--;
    seg_bus.valid   <= 1'b1;
    seg_bus.start_x <= sg.s[0];
    seg_bus.start_y <= sg.s[1];
    seg_bus.start_z <= sg.s[2];
    seg_bus.end_x   <= sg.e[0];
    seg_bus.end_y   <= sg.e[1];
    seg_bus.end_z   <= sg.e[2];
    row_typed       <= typed;
    row_hit         <= hit;
    do @(posedge clk); while (!(seg_bus.valid && seg_bus.ready));
    items_sent++;
  endtask

  // Stop offering and wait until every accepted segment has its hit flag back
  task automatic drain();
    seg_bus.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: track register writes, queue the expected flag for each accepted
  // segment, check each accepted hit flag, and run the watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    coord_t p0 [3];
    coord_t p1 [3];
    logic   want;
    bit     moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_bus.valid && cfg_bus.ready) begin
        moved = 1'b1;
        case (cfg_reg_e'(cfg_bus.index))
          RegMinX: box_lo[0] = cfg_bus.data;
          RegMinY: box_lo[1] = cfg_bus.data;
          RegMinZ: box_lo[2] = cfg_bus.data;
          RegMaxX: box_hi[0] = cfg_bus.data;
          RegMaxY: box_hi[1] = cfg_bus.data;
          RegMaxZ: box_hi[2] = cfg_bus.data;
          default: ;  // unmapped index, dropped by the block
        endcase
      end
      if (seg_bus.valid && seg_bus.ready) begin
        moved = 1'b1;
        p0 = '{seg_bus.start_x, seg_bus.start_y, seg_bus.start_z};
        p1 = '{seg_bus.end_x, seg_bus.end_y, seg_bus.end_z};
        hit_expect_q.insert(hit_expect_q.size(),
                            row_typed ? row_hit : predict_hit(p0, p1));
      end
      if (hit_bus.valid && hit_bus.ready) begin
        moved = 1'b1;
        results_seen++;
        if (hit_expect_q.size() == 0) begin
          err_count++;
          $display("%0t ns: hit item with none pending, expected nothing, got %0b",
                   $time, hit_bus.hit);
        end else begin
          want = hit_expect_q.pop_front();
          if (hit_bus.hit !== want) begin
            err_count++;
            $display("%0t ns: hit mismatch, expected %0b, got %0b",
                     $time, want, hit_bus.hit);
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
        $display("** segment_box_overlap_test: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: switch at random between stall patterns, take a rare random hold,
  // and once hold off for a long stretch after 60 items so the pipe fills and
  // the block stops taking segments
  // --------------------------------------------------------------------------
  initial begin
    int taken;
    int hold_left;
    int mode;
    int mode_left;
    bit long_hold_done;
    taken          = 0;
    hold_left      = 0;
    mode           = 0;
    mode_left      = 0;
    long_hold_done = 1'b0;
    hit_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hit_bus.valid && hit_bus.ready) taken++;
      if (hold_left > 0) begin
        hold_left--;
        hit_bus.ready <= 1'b0;
      end else if (!long_hold_done && taken >= 60) begin
        long_hold_done = 1'b1;
        hold_left      = LongHold;
        hit_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 999) == 0) begin
        hold_left      = $urandom_range(40, 100);
        hit_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       hit_bus.ready <= 1'b1;                          // never stall
          1:       hit_bus.ready <= ($urandom_range(0, 3) != 0);  // light stalls
          2:       hit_bus.ready <= (mode_left % 3 == 0);         // fixed beat
          default: hit_bus.ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int     cur_box;
    int     box_kind, seg_kind, surf_axis, flat_axis;
    int     ctr, half, x0, x1, margin, lo_i, hi_i;
    coord_t lo [3];
    coord_t hi [3];
    seg_t   sg;

    // Hold every input at a known value from time zero
    rst_n           <= 1'b0;
    seg_bus.valid   <= 1'b0;
    seg_bus.start_x <= '0;
    seg_bus.start_y <= '0;
    seg_bus.start_z <= '0;
    seg_bus.end_x   <= '0;
    seg_bus.end_y   <= '0;
    seg_bus.end_z   <= '0;
    cfg_bus.valid   <= 1'b0;
    cfg_bus.index   <= '0;
    cfg_bus.data    <= '0;
    row_typed       <= 1'b0;
    row_hit         <= 1'b0;

    // Directed rows; coordinates are Q8.8, so 256 is one unit
    // Reset box is a single point at the origin
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 1'b1);
    add_row(0, 256, 0, 0, 256, 0, 0, 1, 1'b0);
    add_row(0, -256, -256, -256, 256, 256, 256, 1, 1'b1);
    // Unit cube: point inside, on a face, just off a face, on a corner
    add_row(1, 0, 0, 0, 0, 0, 0, 1, 1'b1);
    add_row(1, 256, 0, 0, 256, 0, 0, 1, 1'b1);
    add_row(1, 257, 0, 0, 257, 0, 0, 1, 1'b0);
    add_row(1, -256, -256, -256, -256, -256, -256, 1, 1'b1);
    // Field extremes as points far out, then as long segments through the cube
    add_row(1, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1'b0);
    add_row(1, -32768, -32768, -32768, -32768, -32768, -32768, 1, 1'b0);
    add_row(1, -32768, -32768, -32768, 32767, 32767, 32767, 1, 1'b1);
    add_row(1, -32768, 0, 0, 32767, 0, 0, 1, 1'b1);
    add_row(1, 0, -32768, 0, 0, 32767, 0, 1, 1'b1);
    // Separated by a cross axis only, grazing an edge, short miss on a face
    add_row(1, 600, 0, 0, 0, 600, 0, 0, 1'b0);
    add_row(1, 512, 0, 0, 0, 512, 0, 0, 1'b0);
    add_row(1, 0, 0, 1024, 0, 0, 257, 0, 1'b0);
    add_row(1, 32767, -32768, 32767, -32768, 32767, -32768, 0, 1'b0);
    // Full-range box
    add_row(2, 32767, 32767, 32767, 32767, 32767, 32767, 1, 1'b1);
    add_row(2, -32768, -32768, -32768, -32768, -32768, -32768, 1, 1'b1);
    add_row(2, 32767, -32768, 0, -32768, 32767, 0, 0, 1'b0);
    // Inverted on x: no reordering, the negative extent goes into the compares
    add_row(3, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    add_row(3, -32768, 0, 0, 32767, 0, 0, 0, 1'b0);
    add_row(3, 300, 0, 0, 300, 0, 0, 0, 1'b0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: the first rows run on the reset box, unwritten
    cur_box = 0;
    bursty  = 1'b0;
    foreach (seg_rows[i]) begin
      if (seg_rows[i].box_sel != cur_box) begin
        drain();
        cur_box = seg_rows[i].box_sel;
        load_box(dir_box_lo[cur_box], dir_box_hi[cur_box], cur_box == 1);
      end
      send_segment(seg_rows[i].seg, seg_rows[i].typed, seg_rows[i].hit);
    end
    drain();

    // Random phases: new box each phase, segments mostly aimed near the box
    for (int p = 0; p < NumPhases; p++) begin
      box_kind  = (p < 6) ? p : $urandom_range(0, 5);
      flat_axis = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++) begin
        ctr  = rand16();
        half = $urandom_range(1, 2048);
        x0   = rand16();
        x1   = rand16();
        case (box_kind)
          1: begin                     // full range
            lo[a] = coord_t'(-32768);
            hi[a] = coord_t'(32767);
          end
          2: begin                     // sorted, anywhere
            lo[a] = coord_t'((x0 < x1) ? x0 : x1);
            hi[a] = coord_t'((x0 < x1) ? x1 : x0);
          end
          5: begin                     // corners in any order
            lo[a] = coord_t'(x0);
            hi[a] = coord_t'(x1);
          end
          default: begin               // small box around a random center
            lo[a] = clamp16(ctr - half);
            hi[a] = clamp16(ctr + half);
          end
        endcase
      end
      // Turn one axis inside out, or flatten it to zero extent
      if (box_kind == 3) begin
        x0             = lo[flat_axis];
        lo[flat_axis]  = hi[flat_axis];
        hi[flat_axis]  = coord_t'(x0);
      end else if (box_kind == 4) begin
        hi[flat_axis] = lo[flat_axis];
      end
      load_box(lo, hi, $urandom_range(0, 1));

      bursty     = (p % 3 != 0);
      burst_left = 0;
      for (int n = 0; n < PhaseItems; n++) begin
        seg_kind  = $urandom_range(0, 9);
        surf_axis = $urandom_range(0, 2);
        for (int a = 0; a < 3; a++) begin
          lo_i   = int'(lo[a]);
          hi_i   = int'(hi[a]);
          margin = ((hi_i > lo_i) ? hi_i - lo_i : lo_i - hi_i) / 2 + 64;
          case (seg_kind)
            5: begin                   // one end inside, the other anywhere
              sg.s[a] = pick_near(lo_i, hi_i, 0);
              sg.e[a] = coord_t'(rand16());
            end
            6: begin                   // point near the box
              sg.s[a] = pick_near(lo_i, hi_i, 16);
              sg.e[a] = sg.s[a];
            end
            7: begin                   // touching a face exactly
              if (a == surf_axis) begin
                sg.s[a] = $urandom_range(0, 1) ? lo[a] : hi[a];
              end else begin
                sg.s[a] = pick_near(lo_i, hi_i, 0);
              end
              sg.e[a] = $urandom_range(0, 1) ? sg.s[a] : pick_near(lo_i, hi_i, margin);
            end
            8, 9: begin                // anything at all
              sg.s[a] = coord_t'(rand16());
              sg.e[a] = coord_t'(rand16());
            end
            default: begin             // both ends around the box
              sg.s[a] = pick_near(lo_i, hi_i, margin);
              sg.e[a] = pick_near(lo_i, hi_i, margin);
            end
          endcase
        end
        send_segment(sg, 1'b0, 1'b0);
      end
      drain();
    end

    // Let any stray item surface before the verdict
    repeat (DrainWait) @(posedge clk);
    if (hit_expect_q.size() != 0) begin
      err_count++;
      $display("%0t ns: hit items missing, expected %0d more, got 0",
               $time, hit_expect_q.size());
    end
    if (err_count == 0) begin
      $display("** segment_box_overlap_test: PASSED **");
    end else begin
      $display("** segment_box_overlap_test: FAILED **");
    end
    $finish;
  end

endmodule
